[hw/rtl/prd_pkg.sv]
// Shared types, constants and helpers of the pixel ray direction core.
package prd_pkg;

  localparam int PixelBitsDefault = 12;
  localparam int PixelW    = 12;
  localparam int CoefW     = 32;
  localparam int PosFrac   = 16;
  localparam int NormBits  = 30;
  localparam int SumW      = 2 * NormBits + 2;
  localparam int RootW     = NormBits + 1;
  localparam int DirW      = 18;
  localparam int QuotW     = 18;
  localparam int InTdataW  = 8 * ((2 * PixelW + 7) / 8);
  localparam int OutTdataW = 8 * ((3 * DirW + 7) / 8);
  localparam int CfgIdxW   = 8;
  localparam int CfgDataW  = 64;

  localparam logic [CfgIdxW-1:0] CFG_ROW_X  = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROW_Y  = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROW_Z  = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_ROW_W  = 8'd3;
  localparam logic [CfgIdxW-1:0] CFG_OFF_XY = 8'd4;
  localparam logic [CfgIdxW-1:0] CFG_OFF_ZW = 8'd5;
  localparam logic [CfgIdxW-1:0] CFG_POS_XY = 8'd6;
  localparam logic [CfgIdxW-1:0] CFG_POS_Z  = 8'd7;

  typedef struct packed {
    logic [63:0] row_x;
    logic [63:0] row_y;
    logic [63:0] row_z;
    logic [63:0] row_w;
    logic [63:0] off_xy;
    logic [63:0] off_zw;
    logic [63:0] pos_xy;
    logic [31:0] pos_z;
  } prd_cfg_t;

  typedef struct packed {
    logic       valid;
    logic       degen;
    logic [2:0] neg;
  } prd_tag_t;

  function automatic int d_width(int pb);
    return pb + 2 * CoefW + 3;
  endfunction

  function automatic logic signed [CoefW-1:0] lo_half(logic [63:0] v);
    return $signed(v[31:0]);
  endfunction

  function automatic logic signed [CoefW-1:0] hi_half(logic [63:0] v);
    return $signed(v[63:32]);
  endfunction

endpackage

[hw/rtl/pixel_ray_direction_core.sv]
// Pixel ray direction core: one pixel coordinate in, one unit ray direction out.
// The core accepts one pixel per clock unless the output stalls. Each direction
// passes the affine transform stages, the scaling and sum-of-squares stages, 31
// square-root stages with one root bit each, 19 divider stages and the output
// register. Most stages lie in the square-root and divider pipelines. When a
// result is held because the sink is not ready, the pipeline keeps running until
// its last stage is full. The user writes registers over the cfg port only while no
// pixel is in flight; the core does not enforce it. Writes take effect at once.
module pixel_ray_direction_core import prd_pkg::*; #(
  parameter int PIXEL_BITS = PixelBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,   // pixel_x, pixel_y
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata,   // dir_x, dir_y, dir_z, zero fill
  output logic                 m_axis_tuser,   // degenerate
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int DW = d_width(PIXEL_BITS);

  prd_cfg_t               cfg_q;
  logic                   en;
  logic [PIXEL_BITS-1:0]  px, py;
  logic                   aff_valid, aff_degen, aff_wneg;
  logic signed [DW-1:0]   aff_d [3];
  prd_tag_t               norm_tag, sqrt_tag, div_tag;
  logic [NormBits-1:0]    norm_c [3];
  logic [NormBits-1:0]    sqrt_c [3];
  logic [SumW-1:0]        norm_sum;
  logic [3*NormBits-1:0]  side_in, side_out;
  logic [RootW-1:0]       root;
  logic [QuotW-1:0]       quo [3];
  logic [DirW-1:0]        dir [3];
  logic                   out_valid_q, out_valid_d;
  logic [OutTdataW-1:0]   out_data_q;
  logic                   out_user_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ROW_X:  cfg_q.row_x  <= cfg_data_i;
        CFG_ROW_Y:  cfg_q.row_y  <= cfg_data_i;
        CFG_ROW_Z:  cfg_q.row_z  <= cfg_data_i;
        CFG_ROW_W:  cfg_q.row_w  <= cfg_data_i;
        CFG_OFF_XY: cfg_q.off_xy <= cfg_data_i;
        CFG_OFF_ZW: cfg_q.off_zw <= cfg_data_i;
        CFG_POS_XY: cfg_q.pos_xy <= cfg_data_i;
        CFG_POS_Z:  cfg_q.pos_z  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  for (genvar b = 0; b < PIXEL_BITS; b++) begin : g_pix
    if (b < PixelW) begin : g_bit
      assign px[b] = s_axis_tdata[b];
      assign py[b] = s_axis_tdata[PixelW + b];
    end else begin : g_zero
      assign px[b] = 1'b0;
      assign py[b] = 1'b0;
    end
  end

  // The pipeline only halts when its last stage holds an item that cannot move on.
  assign en = !(div_tag.valid && out_valid_q && !m_axis_tready);
  assign s_axis_tready = en;

  prd_affine #(.PIXEL_BITS(PIXEL_BITS)) u_affine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .px_i    (px),
    .py_i    (py),
    .cfg_i   (cfg_q),
    .valid_o (aff_valid),
    .degen_o (aff_degen),
    .wneg_o  (aff_wneg),
    .d_o     (aff_d)
  );

  prd_norm #(.D_WIDTH(DW)) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (aff_valid),
    .degen_i (aff_degen),
    .wneg_i  (aff_wneg),
    .d_i     (aff_d),
    .tag_o   (norm_tag),
    .c_o     (norm_c),
    .sum_o   (norm_sum)
  );

  assign side_in = {norm_c[2], norm_c[1], norm_c[0]};

  prd_isqrt #(.SIDE_W(3 * NormBits)) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (norm_tag),
    .side_i (side_in),
    .rad_i  (norm_sum),
    .tag_o  (sqrt_tag),
    .side_o (side_out),
    .root_o (root)
  );

  assign sqrt_c[0] = side_out[NormBits-1:0];
  assign sqrt_c[1] = side_out[2*NormBits-1:NormBits];
  assign sqrt_c[2] = side_out[3*NormBits-1:2*NormBits];

  prd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (sqrt_tag),
    .c_i    (sqrt_c),
    .len_i  (root),
    .tag_o  (div_tag),
    .q_o    (quo)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (div_tag.degen) begin
        dir[i] = '0;
      end else if (div_tag.neg[i]) begin
        dir[i] = DirW'(-quo[i]);
      end else begin
        dir[i] = DirW'(quo[i]);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (en && div_tag.valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && div_tag.valid) begin
      out_data_q <= OutTdataW'({dir[2], dir[1], dir[0]});
      out_user_q <= div_tag.degen;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

[hw/rtl/prd_affine.sv]
// Affine transform of the pixel and scaled difference to the camera position.
module prd_affine import prd_pkg::*; #(
  parameter int PIXEL_BITS = PixelBitsDefault,
  localparam int DW = d_width(PIXEL_BITS)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [PIXEL_BITS-1:0]  px_i,
  input  logic [PIXEL_BITS-1:0]  py_i,
  input  prd_cfg_t               cfg_i,
  output logic                   valid_o,
  output logic                   degen_o,
  output logic                   wneg_o,
  output logic signed [DW-1:0]   d_o [3]
);

  localparam int PW  = CoefW + PIXEL_BITS;
  localparam int VW  = PW + 2;
  localparam int WL  = 25;
  localparam int WH  = VW - WL;
  localparam int PLW = WL + CoefW + 1;
  localparam int PHW = WH + CoefW;

  logic signed [CoefW-1:0] coef_a [4];
  logic signed [CoefW-1:0] coef_b [4];
  logic signed [CoefW-1:0] offs [4];
  logic signed [CoefW-1:0] pos [3];

  logic                 va_q, vb_q, vc_q, vd_q;
  logic signed [PW-1:0] pa_q [4];
  logic signed [PW-1:0] pb_q [4];
  logic signed [VW-1:0] v_q [4];
  logic signed [VW-1:0] vc_data_q [3];
  logic signed [PLW-1:0] pl_q [3];
  logic signed [PHW-1:0] ph_q [3];
  logic                 wzero_c_q, wneg_c_q, wzero_d_q, wneg_d_q;
  logic signed [DW-1:0] d_q [3];

  assign coef_a[0] = lo_half(cfg_i.row_x);
  assign coef_b[0] = hi_half(cfg_i.row_x);
  assign coef_a[1] = lo_half(cfg_i.row_y);
  assign coef_b[1] = hi_half(cfg_i.row_y);
  assign coef_a[2] = lo_half(cfg_i.row_z);
  assign coef_b[2] = hi_half(cfg_i.row_z);
  assign coef_a[3] = lo_half(cfg_i.row_w);
  assign coef_b[3] = hi_half(cfg_i.row_w);
  assign offs[0]   = lo_half(cfg_i.off_xy);
  assign offs[1]   = hi_half(cfg_i.off_xy);
  assign offs[2]   = lo_half(cfg_i.off_zw);
  assign offs[3]   = hi_half(cfg_i.off_zw);
  assign pos[0]    = lo_half(cfg_i.pos_xy);
  assign pos[1]    = hi_half(cfg_i.pos_xy);
  assign pos[2]    = $signed(cfg_i.pos_z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        pa_q[i] <= PW'(coef_a[i]) * PW'($signed({1'b0, px_i}));
        pb_q[i] <= PW'(coef_b[i]) * PW'($signed({1'b0, py_i}));
        v_q[i]  <= VW'(pa_q[i]) + VW'(pb_q[i]) + VW'(offs[i]);
      end
      for (int i = 0; i < 3; i++) begin
        vc_data_q[i] <= v_q[i];
        pl_q[i] <= PLW'($signed({1'b0, v_q[3][WL-1:0]})) * PLW'(pos[i]);
        ph_q[i] <= PHW'($signed(v_q[3][VW-1:WL])) * PHW'(pos[i]);
        d_q[i]  <= (DW'(vc_data_q[i]) <<< PosFrac)
                 - ((DW'(ph_q[i]) <<< WL) + DW'(pl_q[i]));
      end
      wzero_c_q <= (v_q[3] == '0);
      wneg_c_q  <= v_q[3][VW-1];
      wzero_d_q <= wzero_c_q;
      wneg_d_q  <= wneg_c_q;
    end
  end

  assign valid_o = vd_q;
  assign degen_o = wzero_d_q;
  assign wneg_o  = wneg_d_q;
  assign d_o     = d_q;

endmodule

[hw/rtl/prd_norm.sv]
// Magnitude, leading-bit search, scaling to 30 bits and sum of squares.
module prd_norm import prd_pkg::*; #(
  parameter int D_WIDTH = d_width(PixelBitsDefault)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic                       degen_i,
  input  logic                       wneg_i,
  input  logic signed [D_WIDTH-1:0]  d_i [3],
  output prd_tag_t                   tag_o,
  output logic [NormBits-1:0]        c_o [3],
  output logic [SumW-1:0]            sum_o
);

  localparam int NC = (D_WIDTH + 7) / 8;
  localparam int SW = $clog2(D_WIDTH + 1);

  prd_tag_t             tag_e_q, tag_f_q, tag_g_q, tag_h_q, tag_i_q, tag_j_q;
  logic [D_WIDTH-1:0]   mag_e_q [3];
  logic [D_WIDTH-1:0]   mag_f_q [3];
  logic [D_WIDTH-1:0]   mag_g_q [3];
  logic [NC-1:0]        nz_d, nz_f_q;
  logic [2:0]           idx_d [NC];
  logic [2:0]           idx_f_q [NC];
  logic [NC*8-1:0]      orw;
  logic [SW-1:0]        blen;
  logic [SW-1:0]        shamt_g_q;
  logic [D_WIDTH-1:0]   shl [3];
  logic [NormBits-1:0]  c_h_q [3];
  logic [NormBits-1:0]  c_i_q [3];
  logic [NormBits-1:0]  c_j_q [3];
  logic [2*NormBits-1:0] sq_i_q [3];
  logic [SumW-1:0]      sum_j_q;
  prd_tag_t             tag_e_d, tag_g_d;

  always_comb begin
    tag_e_d.valid = valid_i;
    tag_e_d.degen = degen_i;
    for (int i = 0; i < 3; i++) begin
      tag_e_d.neg[i] = d_i[i][D_WIDTH-1] ^ wneg_i;
    end
  end

  assign orw = (NC*8)'(mag_e_q[0] | mag_e_q[1] | mag_e_q[2]);

  always_comb begin
    for (int j = 0; j < NC; j++) begin
      nz_d[j]  = |orw[j*8 +: 8];
      idx_d[j] = '0;
      for (int b = 0; b < 8; b++) begin
        if (orw[j*8 + b]) begin
          idx_d[j] = 3'(b);
        end
      end
    end
  end

  always_comb begin
    blen = '0;
    for (int j = 0; j < NC; j++) begin
      if (nz_f_q[j]) begin
        blen = SW'(j * 8) + SW'(idx_f_q[j]) + SW'(1);
      end
    end
    tag_g_d = tag_f_q;
    tag_g_d.degen = tag_f_q.degen | (nz_f_q == '0);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shl[i] = mag_g_q[i] << shamt_g_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_e_q <= '0;
      tag_f_q <= '0;
      tag_g_q <= '0;
      tag_h_q <= '0;
      tag_i_q <= '0;
      tag_j_q <= '0;
    end else if (en_i) begin
      tag_e_q <= tag_e_d;
      tag_f_q <= tag_e_q;
      tag_g_q <= tag_g_d;
      tag_h_q <= tag_g_q;
      tag_i_q <= tag_h_q;
      tag_j_q <= tag_i_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        mag_e_q[i] <= d_i[i][D_WIDTH-1] ? D_WIDTH'(-d_i[i]) : D_WIDTH'(d_i[i]);
        mag_f_q[i] <= mag_e_q[i];
        mag_g_q[i] <= mag_f_q[i];
        c_h_q[i]   <= shl[i][D_WIDTH-1 -: NormBits];
        sq_i_q[i]  <= (2*NormBits)'(c_h_q[i]) * (2*NormBits)'(c_h_q[i]);
        c_i_q[i]   <= c_h_q[i];
        c_j_q[i]   <= c_i_q[i];
      end
      nz_f_q    <= nz_d;
      idx_f_q   <= idx_d;
      shamt_g_q <= SW'(D_WIDTH) - blen;
      sum_j_q   <= SumW'(sq_i_q[0]) + SumW'(sq_i_q[1]) + SumW'(sq_i_q[2]);
    end
  end

  assign tag_o = tag_j_q;
  assign c_o   = c_j_q;
  assign sum_o = sum_j_q;

endmodule

[hw/rtl/prd_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
module prd_isqrt import prd_pkg::*; #(
  parameter int SIDE_W = 3 * NormBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  prd_tag_t          tag_i,
  input  logic [SIDE_W-1:0] side_i,
  input  logic [SumW-1:0]   rad_i,
  output prd_tag_t          tag_o,
  output logic [SIDE_W-1:0] side_o,
  output logic [RootW-1:0]  root_o
);

  prd_tag_t          tag_q  [RootW];
  logic [SIDE_W-1:0] side_q [RootW];
  logic [SumW-1:0]   rem_q  [RootW];
  logic [SumW-1:0]   root_q [RootW];

  for (genvar s = 0; s < RootW; s++) begin : g_stage
    localparam int K = RootW - 1 - s;
    localparam logic [SumW:0] BitV = (SumW+1)'(1) << (2 * K);

    prd_tag_t          tag_in;
    logic [SIDE_W-1:0] side_in;
    logic [SumW-1:0]   rem_in;
    logic [SumW-1:0]   root_in;
    logic [SumW:0]     trial;
    logic              ge;

    if (s == 0) begin : g_first
      assign tag_in  = tag_i;
      assign side_in = side_i;
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign tag_in  = tag_q[s-1];
      assign side_in = side_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    assign trial = {1'b0, root_in} + BitV;
    assign ge    = ({1'b0, rem_in} >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[s] <= '0;
      end else if (en_i) begin
        tag_q[s] <= tag_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= side_in;
        rem_q[s]  <= ge ? (rem_in - trial[SumW-1:0]) : rem_in;
        root_q[s] <= ge ? ((root_in >> 1) + BitV[SumW-1:0]) : (root_in >> 1);
      end
    end
  end

  assign tag_o  = tag_q[RootW-1];
  assign side_o = side_q[RootW-1];
  assign root_o = root_q[RootW-1][RootW-1:0];

endmodule

[hw/rtl/prd_div.sv]
// Pipelined rounding division of three components by the vector length.
module prd_div import prd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  prd_tag_t            tag_i,
  input  logic [NormBits-1:0] c_i [3],
  input  logic [RootW-1:0]    len_i,
  output prd_tag_t            tag_o,
  output logic [QuotW-1:0]    q_o [3]
);

  localparam int NumW = NormBits + PosFrac + 1;
  localparam int CW   = RootW + QuotW;

  prd_tag_t          tag0_q;
  logic [RootW-1:0]  len0_q;
  logic [NumW-1:0]   num0_q [3];

  prd_tag_t          tag_q [QuotW];
  logic [RootW-1:0]  len_q [QuotW];
  logic [NumW-1:0]   rem_q [QuotW][3];
  logic [QuotW-1:0]  quo_q [QuotW][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag0_q <= '0;
    end else if (en_i) begin
      tag0_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len0_q <= len_i;
      for (int l = 0; l < 3; l++) begin
        num0_q[l] <= NumW'({c_i[l], {PosFrac{1'b0}}}) + NumW'(len_i >> 1);
      end
    end
  end

  for (genvar s = 0; s < QuotW; s++) begin : g_stage
    localparam int K = QuotW - 1 - s;

    prd_tag_t         tag_in;
    logic [RootW-1:0] len_in;
    logic [NumW-1:0]  rem_in [3];
    logic [QuotW-1:0] quo_in [3];
    logic [CW-1:0]    trial;
    logic [2:0]       ge;

    if (s == 0) begin : g_first
      assign tag_in = tag0_q;
      assign len_in = len0_q;
      assign rem_in = num0_q;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign quo_in[l] = '0;
      end
    end else begin : g_next
      assign tag_in = tag_q[s-1];
      assign len_in = len_q[s-1];
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign trial = CW'(len_in) << K;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        ge[l] = (CW'(rem_in[l]) >= trial);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[s] <= '0;
      end else if (en_i) begin
        tag_q[s] <= tag_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        len_q[s] <= len_in;
        for (int l = 0; l < 3; l++) begin
          rem_q[s][l] <= ge[l] ? NumW'(CW'(rem_in[l]) - trial) : rem_in[l];
          quo_q[s][l] <= {quo_in[l][QuotW-2:0], ge[l]};
        end
      end
    end
  end

  assign tag_o = tag_q[QuotW-1];
  assign q_o   = quo_q[QuotW-1];

endmodule

[hw/rtl/prd_checker.sv]
// Port-level checks of the pixel ray direction core and their binding.
module prd_checker import prd_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata,
  input logic                 m_axis_tuser
);

  logic signed [DirW-1:0] dx, dy, dz;

  assign dx = $signed(m_axis_tdata[DirW-1:0]);
  assign dy = $signed(m_axis_tdata[2*DirW-1:DirW]);
  assign dz = $signed(m_axis_tdata[3*DirW-1:2*DirW]);

  // A degenerate ray carries an all-zero direction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("degenerate item with nonzero direction");

  // Every component of a unit vector lies within plus and minus one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      dx <= 18'sd65536 && dx >= -18'sd65536 &&
      dy <= 18'sd65536 && dy >= -18'sd65536 &&
      dz <= 18'sd65536 && dz >= -18'sd65536)
    else $error("direction component out of unit range");

  // A valid ray has at least one nonzero component.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (dx != 0 || dy != 0 || dz != 0))
    else $error("non-degenerate item with zero direction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output item changed");

endmodule

bind pixel_ray_direction_core prd_checker u_prd_checker (.*);
